// ===== design/cfc_pkg.sv =====
// Shared types, constants and the bytewise CRC-32 step for the chunk frame checker.
// No dependencies; imported by the queue and the top level.
package cfc_pkg;

  localparam int HEADER_BYTES = 25;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // configuration register indexes
  localparam logic REG_MAGIC = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_SHORT = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_SIZE_OVERFLOW = 3'd4,
    ST_CRC_MISMATCH = 3'd5
  } status_t;

  typedef struct packed {
    logic item_kind;
    logic [7:0] payload_byte;
    status_t status;
    logic [31:0] chunk_total;
    logic [31:0] chunk_position;
    logic [31:0] payload_length;
    logic [31:0] uncompressed_length;
    logic run_end;
  } result_t;

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/chunk_frame_checker_crc32_top.sv =====
// Top level of the chunk frame checker: header parse, payload forward and CRC-32 check.
// Depends on cfc_pkg and cfc_queue.
//
// Usage: feed a stored chunk one byte per transaction on in_byte, with final_byte
// set on its last byte. The first 25 bytes form a big-endian header (magic,
// version, total chunks, chunk index, payload size, original size, CRC).
// Every byte inside the declared payload size leaves as a payload transaction
// (item_kind 0), registered into the result queue when it is accepted; the final
// byte adds one status transaction (item_kind 1, run_end 1) that carries the
// verdict and the header fields. Payload goes out before the verdict, so drop it
// when status is not ok. Throughput: one byte per cycle while in_stall is low; the
// header shift and the bytewise CRC update both complete in the accept cycle.
// Results leave in order from the head of the result queue (four entries by default).
// When the receiver stalls, the queue fills; in_stall rises once fewer than two
// free entries remain, so a final byte can always deliver both of its results.
// Reset (rst, synchronous) clears the parser state, the queue and both
// configuration registers. Write expected_magic and expected_version while idle.
module chunk_frame_checker_crc32_top #(
  parameter int QUEUE_DEPTH = cfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // configuration write port
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input byte channel
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_byte,
  input  logic final_byte,
  // result channel
  output logic out_valid,
  input  logic out_stall,
  output logic item_kind,
  output logic [7:0] payload_byte,
  output logic [2:0] status,
  output logic [31:0] chunk_total,
  output logic [31:0] chunk_position,
  output logic [31:0] payload_length,
  output logic [31:0] uncompressed_length,
  output logic run_end
);
  import cfc_pkg::*;

  localparam logic [31:0] HDR = 32'(HEADER_BYTES);

  // configuration
  logic [31:0] expected_magic;
  logic [7:0] expected_version;

  // parser state
  logic [31:0] byte_counter, byte_counter_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [7:0] version_reg, version_reg_next;
  logic [31:0] total_shift, total_shift_next;
  logic [31:0] index_shift, index_shift_next;
  logic [31:0] size_shift, size_shift_next;
  logic [31:0] original_shift, original_shift_next;
  logic [31:0] stored_crc_shift, stored_crc_shift_next;
  logic [31:0] crc_accumulator, crc_accumulator_next;

  logic in_fire;
  logic is_payload;
  logic is_short;
  logic [32:0] needed_len;
  status_t verdict;
  result_t payload_item, status_item, push_data_a, queue_head;
  logic push_a, push_b, queue_full2;

  assign in_fire = in_valid && !in_stall;
  assign in_stall = queue_full2;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= '0;
      expected_version <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC: expected_magic <= cfg_data[31:0];
        REG_VERSION: expected_version <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // route the byte into the header field its position selects, or into the CRC; drop it past the declared size
  always_comb begin
    byte_counter_next = (byte_counter == '1) ? byte_counter : byte_counter + 32'd1;
    magic_shift_next = magic_shift;
    version_reg_next = version_reg;
    total_shift_next = total_shift;
    index_shift_next = index_shift;
    size_shift_next = size_shift;
    original_shift_next = original_shift;
    stored_crc_shift_next = stored_crc_shift;
    crc_accumulator_next = crc_accumulator;
    is_payload = 1'b0;
    priority if (byte_counter < 32'd4) begin
      magic_shift_next = {magic_shift[23:0], in_byte};
    end else if (byte_counter == 32'd4) begin
      version_reg_next = in_byte;
    end else if (byte_counter < 32'd9) begin
      total_shift_next = {total_shift[23:0], in_byte};
    end else if (byte_counter < 32'd13) begin
      index_shift_next = {index_shift[23:0], in_byte};
    end else if (byte_counter < 32'd17) begin
      size_shift_next = {size_shift[23:0], in_byte};
    end else if (byte_counter < 32'd21) begin
      original_shift_next = {original_shift[23:0], in_byte};
    end else if (byte_counter < HDR) begin
      stored_crc_shift_next = {stored_crc_shift[23:0], in_byte};
    end else if ((byte_counter - HDR) < size_shift) begin
      crc_accumulator_next = crc_byte(crc_accumulator, in_byte);
      is_payload = 1'b1;
    end else begin
      // past the declared size: drop the byte
    end
  end

  // verdict on the final byte, from the state including this byte
  assign is_short = (byte_counter_next < HDR);
  assign needed_len = {1'b0, HDR} + {1'b0, size_shift_next};

  always_comb begin
    priority if (is_short) verdict = ST_SHORT;
    else if (magic_shift_next != expected_magic) verdict = ST_BAD_MAGIC;
    else if (version_reg_next != expected_version) verdict = ST_BAD_VERSION;
    else if (needed_len > {1'b0, byte_counter_next}) verdict = ST_SIZE_OVERFLOW;
    else if ((crc_accumulator_next ^ 32'hFFFF_FFFF) != stored_crc_shift_next)
      verdict = ST_CRC_MISMATCH;
    else verdict = ST_OK;
  end

  always_comb begin
    payload_item = '0;
    payload_item.item_kind = 1'b0;
    payload_item.payload_byte = in_byte;
    payload_item.status = ST_OK;

    status_item = '0;
    status_item.item_kind = 1'b1;
    status_item.status = verdict;
    status_item.run_end = 1'b1;
    if (!is_short) begin
      status_item.chunk_total = total_shift_next;
      status_item.chunk_position = index_shift_next;
      status_item.payload_length = size_shift_next;
      status_item.uncompressed_length = original_shift_next;
    end
  end

  // payload result first, status result behind it
  assign push_a = in_fire && (is_payload || final_byte);
  assign push_b = in_fire && is_payload && final_byte;
  assign push_data_a = is_payload ? payload_item : status_item;

  always_ff @(posedge clk) begin
    if (rst || (in_fire && final_byte)) begin
      byte_counter <= '0;
      magic_shift <= '0;
      version_reg <= '0;
      total_shift <= '0;
      index_shift <= '0;
      size_shift <= '0;
      original_shift <= '0;
      stored_crc_shift <= '0;
      crc_accumulator <= '1;
    end else if (in_fire) begin
      byte_counter <= byte_counter_next;
      magic_shift <= magic_shift_next;
      version_reg <= version_reg_next;
      total_shift <= total_shift_next;
      index_shift <= index_shift_next;
      size_shift <= size_shift_next;
      original_shift <= original_shift_next;
      stored_crc_shift <= stored_crc_shift_next;
      crc_accumulator <= crc_accumulator_next;
    end
  end

  cfc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_a(push_a),
    .data_a(push_data_a),
    .push_b(push_b),
    .data_b(status_item),
    .pop(!out_stall),
    .full2(queue_full2),
    .not_empty(out_valid),
    .head(queue_head)
  );

  assign item_kind = queue_head.item_kind;
  assign payload_byte = queue_head.payload_byte;
  assign status = queue_head.status;
  assign chunk_total = queue_head.chunk_total;
  assign chunk_position = queue_head.chunk_position;
  assign payload_length = queue_head.payload_length;
  assign uncompressed_length = queue_head.uncompressed_length;
  assign run_end = queue_head.run_end;

endmodule

// ===== design/cfc_queue.sv =====
// Small result queue that takes up to two transactions per cycle and hands out one.
// Depends on cfc_pkg for the result type.
module cfc_queue #(
  parameter int DEPTH = cfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push_a,
  input  cfc_pkg::result_t data_a,
  input  logic push_b,
  input  cfc_pkg::result_t data_b,
  input  logic pop,
  output logic full2,
  output logic not_empty,
  output cfc_pkg::result_t head
);
  import cfc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t q [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr_b;
  logic [CW-1:0] count, count_next;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  assign wr_ptr_b = bump(wr_ptr);
  assign not_empty = (count != '0);
  assign head = q[rd_ptr];
  // room for two more entries is required before a new transaction is taken
  assign full2 = (count > CW'(DEPTH - 2));

  always_comb begin
    count_next = count + CW'(push_a) + CW'(push_a && push_b) - CW'(pop && not_empty);
  end

  always_ff @(posedge clk) begin
    if (push_a) q[wr_ptr] <= data_a;
    if (push_a && push_b) q[wr_ptr_b] <= data_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push_a) wr_ptr <= push_b ? bump(wr_ptr_b) : wr_ptr_b;
      if (pop && not_empty) rd_ptr <= bump(rd_ptr);
    end
  end

endmodule
